// ===== sv/ale_pkg.sv =====
// Package: widths, operation and status codes, and sequencer states of the list engine.
`timescale 1ns / 1ps

package ale_pkg;

    localparam int DEPTH     = 64;
    localparam int KEY_WIDTH = 32;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Field widths fixed by the stream format
    localparam int FUNC_W   = 3;
    localparam int KEYF_W   = 32;
    localparam int POS_W    = 6;
    localparam int STAT_W   = 2;
    localparam int FOUND_W  = 6;
    localparam int ICOUNT_W = 7;

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam int IN_BITS  = FUNC_W + KEYF_W + POS_W;
    localparam int OUT_BITS = STAT_W + FOUND_W + ICOUNT_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [FUNC_W-1:0] FN_INS_POS   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INS_END   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_REMOVE    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_SEARCH    = 3'd4;
    localparam logic [FUNC_W-1:0] FN_CLEAR     = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BADPOS   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SHIFT,
        S_INS_TAIL,
        S_INS_KEY,
        S_FIND,
        S_RM_SHIFT,
        S_RESP
    } t_state;

endpackage

// ===== sv/ale_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module ale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== sv/array_list_engine_top.sv =====
// Top level of the list engine: request sequencer around the entry memory.
`timescale 1ns / 1ps

// Bounded ordered list of keys held in one RAM, plus an entry count.
// Slave stream carries one request per transfer: func, key and position.
// Master stream returns one result per request: status, found index and
// the count after the operation.
// One request is worked on at a time; the next is taken once the result
// is loaded into the output register, even if that result is not yet taken.
// Steps per request, from acceptance to result loaded:
//   insert at position p: entries from p upward move one place up, top
//   first, then the key is written at p; only the key when p equals the count
//   search: compares from index 0 upward until a match or the count
//   remove: searches likewise, then on a hit moves later entries down a place
//   clear, full, bad position and unused codes go straight to the result
// Moves and compares are paced by the single read and single write port of
// the entry RAM: one entry moves or compares per cycle.
// Reset clears the count, the sequencer state and the valid flags; the RAM is
// not cleared, since only entries below the count are ever used.
// A stalled master side holds the result; the sequencer then waits with
// the next result until the output register is free.
module array_list_engine_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // func [2:0], key [34:3], position [40:35], zero fill above
    input  logic [ale_pkg::IN_W-1:0]  i_s_axis_tdata,
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // status [1:0], found_index [7:2], item_count [14:8], zero fill above
    output logic [ale_pkg::OUT_W-1:0] o_m_axis_tdata
);

    localparam int IDX_W = ale_pkg::IDX_W;
    localparam int CNT_W = ale_pkg::CNT_W;
    localparam int KW    = ale_pkg::KEY_WIDTH;
    localparam int FW    = ale_pkg::FUNC_W;
    localparam int PW    = ale_pkg::POS_W;
    localparam int CW    = ale_pkg::CMP_W;

    ale_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0]          r_count, n_count;
    logic [CNT_W-1:0]          r_ptr, n_ptr;
    logic                      r_pend, n_pend;
    logic [IDX_W-1:0]          r_wa, n_wa;
    logic [IDX_W-1:0]          r_pos, n_pos;
    logic [FW-1:0]             r_func, n_func;
    logic [KW-1:0]             r_key, n_key;
    logic [ale_pkg::STAT_W-1:0] r_status, n_status;
    logic [IDX_W-1:0]          r_found, n_found;
    logic                      r_out_valid, n_out_valid;
    logic [ale_pkg::OUT_W-1:0] r_out_data, n_out_data;

    logic                      ram_we;
    logic [IDX_W-1:0]          ram_waddr;
    logic [KW-1:0]             ram_wdata;
    logic [IDX_W-1:0]          ram_raddr;
    logic [KW-1:0]             ram_rdata;

    logic [FW-1:0]             in_func;
    logic [KW-1:0]             in_key;
    logic [PW-1:0]             in_pos;
    logic [CW-1:0]             eff_pos;
    logic [CW-1:0]             count_w;
    logic                      accept;
    logic                      is_ins;
    logic                      is_full;
    logic                      is_bad;
    logic                      is_find;
    logic                      match;
    logic                      ptr_end;
    logic                      out_free;
    logic                      ins_last;

    assign in_func = i_s_axis_tdata[FW-1:0];
    assign in_key  = i_s_axis_tdata[FW+KW-1:FW];
    assign in_pos  = i_s_axis_tdata[FW+ale_pkg::KEYF_W+PW-1:FW+ale_pkg::KEYF_W];

    assign o_s_axis_tready = (r_state == ale_pkg::S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    assign count_w = CW'(r_count);

    always_comb begin
        unique case (in_func)
            ale_pkg::FN_INS_FRONT: eff_pos = '0;
            ale_pkg::FN_INS_END:   eff_pos = count_w;
            default:               eff_pos = CW'(in_pos);
        endcase
    end

    assign is_ins  = (in_func == ale_pkg::FN_INS_POS) || (in_func == ale_pkg::FN_INS_FRONT)
                     || (in_func == ale_pkg::FN_INS_END);
    assign is_find = (in_func == ale_pkg::FN_REMOVE) || (in_func == ale_pkg::FN_SEARCH);
    assign is_full = (r_count >= CNT_W'(ale_pkg::DEPTH));
    assign is_bad  = (eff_pos > count_w);

    assign match    = r_pend && (ram_rdata == r_key);
    assign ptr_end  = (r_ptr == r_count);
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign ins_last = (r_ptr[IDX_W-1:0] == r_pos);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ale_pkg::S_IDLE: begin
                if (accept) begin
                    if (is_ins) begin
                        if (is_full || is_bad) begin
                            n_state = ale_pkg::S_RESP;
                        end else if (eff_pos == count_w) begin
                            n_state = ale_pkg::S_INS_KEY;
                        end else begin
                            n_state = ale_pkg::S_INS_SHIFT;
                        end
                    end else if (is_find) begin
                        n_state = ale_pkg::S_FIND;
                    end else begin
                        n_state = ale_pkg::S_RESP;
                    end
                end
            end
            ale_pkg::S_INS_SHIFT: begin
                if (ins_last) begin
                    n_state = ale_pkg::S_INS_TAIL;
                end
            end
            ale_pkg::S_INS_TAIL: n_state = ale_pkg::S_INS_KEY;
            ale_pkg::S_INS_KEY:  n_state = ale_pkg::S_RESP;
            ale_pkg::S_FIND: begin
                if (match) begin
                    n_state = (r_func == ale_pkg::FN_REMOVE) ? ale_pkg::S_RM_SHIFT
                                                             : ale_pkg::S_RESP;
                end else if (ptr_end) begin
                    n_state = ale_pkg::S_RESP;
                end
            end
            ale_pkg::S_RM_SHIFT: begin
                if (ptr_end && !r_pend) begin
                    n_state = ale_pkg::S_RESP;
                end
            end
            ale_pkg::S_RESP: begin
                if (out_free) begin
                    n_state = ale_pkg::S_IDLE;
                end
            end
            default: n_state = ale_pkg::S_IDLE;
        endcase
    end

    // Datapath, memory control and result
    always_comb begin
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_pend      = 1'b0;
        n_wa        = r_wa;
        n_pos       = r_pos;
        n_func      = r_func;
        n_key       = r_key;
        n_status    = r_status;
        n_found     = r_found;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        ram_waddr   = r_wa;
        ram_wdata   = ram_rdata;
        ram_raddr   = r_ptr[IDX_W-1:0];

        unique case (r_state)
            ale_pkg::S_IDLE: begin
                if (accept) begin
                    n_func   = in_func;
                    n_key    = in_key;
                    n_pos    = eff_pos[IDX_W-1:0];
                    n_status = ale_pkg::STAT_OK;
                    n_found  = '0;
                    if (is_ins) begin
                        if (is_full) begin
                            n_status = ale_pkg::STAT_FULL;
                        end else if (is_bad) begin
                            n_status = ale_pkg::STAT_BADPOS;
                        end else begin
                            n_ptr = r_count - CNT_W'(1);
                        end
                    end else if (is_find) begin
                        n_ptr = '0;
                    end else if (in_func == ale_pkg::FN_CLEAR) begin
                        n_count = '0;
                    end
                end
            end
            ale_pkg::S_INS_SHIFT: begin
                // read entry ptr, move the previous read one place up
                ram_we = r_pend;
                n_pend = 1'b1;
                n_wa   = r_ptr[IDX_W-1:0] + IDX_W'(1);
                if (!ins_last) begin
                    n_ptr = r_ptr - CNT_W'(1);
                end
            end
            ale_pkg::S_INS_TAIL: begin
                ram_we = 1'b1;
            end
            ale_pkg::S_INS_KEY: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos;
                ram_wdata = r_key;
                n_count   = r_count + CNT_W'(1);
            end
            ale_pkg::S_FIND: begin
                if (match) begin
                    n_found = r_wa;
                    n_ptr   = CNT_W'(r_wa) + CNT_W'(1);
                end else if (ptr_end) begin
                    n_status = ale_pkg::STAT_NOTFOUND;
                end else begin
                    n_pend = 1'b1;
                    n_wa   = r_ptr[IDX_W-1:0];
                    n_ptr  = r_ptr + CNT_W'(1);
                end
            end
            ale_pkg::S_RM_SHIFT: begin
                // read entry ptr, move the previous read one place down
                ram_we = r_pend;
                if (!ptr_end) begin
                    n_pend = 1'b1;
                    n_wa   = r_ptr[IDX_W-1:0] - IDX_W'(1);
                    n_ptr  = r_ptr + CNT_W'(1);
                end else if (!r_pend) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            ale_pkg::S_RESP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = ale_pkg::OUT_W'({
                        ale_pkg::ICOUNT_W'(r_count),
                        ale_pkg::FOUND_W'(r_found),
                        r_status
                    });
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ale_pkg::S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_wa       <= n_wa;
        r_pos      <= n_pos;
        r_func     <= n_func;
        r_key      <= n_key;
        r_status   <= n_status;
        r_found    <= n_found;
        r_out_data <= n_out_data;
    end

    ale_ram #(
        .WIDTH (KW),
        .DEPTH (ale_pkg::DEPTH)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule
